### hdl/spp_pkg.sv
// shared types, constants and the arctangent table for the spherical projection block
`default_nettype none
package spp_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int CW   = 56;
  localparam int AW   = 34;
  localparam int CDW  = 37;
  localparam int PW   = 52;
  localparam int CFGW = 60;
  localparam int IDXW = 3;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    logic  zero;
    ang_t  theta;
    cval_t z;
  } side_t;

  typedef struct packed {
    cval_t re;
    cval_t im;
    ang_t  acc;
    side_t side;
  } work_t;

  typedef enum logic [IDXW-1:0] {
    REG_ROT_ROW0   = 3'd0,
    REG_ROT_ROW1   = 3'd1,
    REG_ROT_ROW2   = 3'd2,
    REG_SHIFT_X    = 3'd3,
    REG_SHIFT_Y    = 3'd4,
    REG_SHIFT_Z    = 3'd5,
    REG_IMAGE_SIZE = 3'd6,
    REG_MAX_DIST   = 3'd7
  } reg_idx_t;

  localparam logic [CFGW-1:0] ROT_ROW0_RST = 60'd262144;
  localparam logic [CFGW-1:0] ROT_ROW1_RST = 60'd274877906944;
  localparam logic [CFGW-1:0] ROT_ROW2_RST = 60'd288230376151711744;
  localparam logic [31:0]     MAX_DIST_RST = 32'd655360;

  localparam logic [31:0] GAIN_INV  = 32'h9B74EDA8;
  localparam ang_t        HALF_TURN = 34'sd2147483648;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

endpackage
`default_nettype wire

### hdl/spp_front.sv
// front end: pose transform of each point and half-plane fold
`default_nettype none
module spp_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_take,
  input  wire logic signed [31:0]         in_point_x,
  input  wire logic signed [31:0]         in_point_y,
  input  wire logic signed [31:0]         in_point_z,
  input  wire logic [spp_pkg::CFGW-1:0]   rot_row0,
  input  wire logic [spp_pkg::CFGW-1:0]   rot_row1,
  input  wire logic [spp_pkg::CFGW-1:0]   rot_row2,
  input  wire logic signed [31:0]         shift_x,
  input  wire logic signed [31:0]         shift_y,
  input  wire logic signed [31:0]         shift_z,
  output logic                            out_valid,
  output spp_pkg::work_t                  out_work
);

  logic [spp_pkg::CFGW-1:0]        row [3];
  logic signed [31:0]              pnt [3];
  logic signed [31:0]              sft [3];
  logic signed [spp_pkg::PW-1:0]   prod_r [3][3];
  logic                            v1_r;
  logic signed [spp_pkg::PW+1:0]   sum [3];
  logic signed [spp_pkg::CDW-1:0]  coord_nxt [3];
  logic signed [spp_pkg::CDW-1:0]  coord_r [3];
  logic                            v2_r;
  spp_pkg::cval_t                  cx, cy, cz;
  spp_pkg::work_t                  work_nxt;

  always_comb begin
    row[0] = rot_row0;
    row[1] = rot_row1;
    row[2] = rot_row2;
    pnt[0] = in_point_x;
    pnt[1] = in_point_y;
    pnt[2] = in_point_z;
    sft[0] = shift_x;
    sft[1] = shift_y;
    sft[2] = shift_z;
  end

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_take;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= $signed(row[r][20*c +: 20]) * pnt[c];
      end
    end
  end

  // sum, round and translate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = (spp_pkg::PW+2)'(prod_r[r][0]) + (spp_pkg::PW+2)'(prod_r[r][1])
             + (spp_pkg::PW+2)'(prod_r[r][2]);
      coord_nxt[r] = spp_pkg::CDW'((sum[r] + 54'sd131072) >>> 18)
                   + spp_pkg::CDW'(sft[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int r = 0; r < 3; r++) begin
      coord_r[r] <= coord_nxt[r];
    end
  end

  // guard bits and half-plane fold
  always_comb begin
    cx = spp_pkg::cval_t'(coord_r[0]) <<< 16;
    cy = spp_pkg::cval_t'(coord_r[1]) <<< 16;
    cz = spp_pkg::cval_t'(coord_r[2]) <<< 16;
    work_nxt.side.zero  = (cx == '0) && (cy == '0);
    work_nxt.side.theta = '0;
    work_nxt.side.z     = cz;
    if (cy[spp_pkg::CW-1]) begin
      work_nxt.re  = -cy;
      work_nxt.im  = -cx;
      work_nxt.acc = cx[spp_pkg::CW-1] ? -spp_pkg::HALF_TURN : spp_pkg::HALF_TURN;
    end else begin
      work_nxt.re  = cy;
      work_nxt.im  = cx;
      work_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2_r;
    end
    out_work <= work_nxt;
  end

endmodule
`default_nettype wire

### hdl/spp_fifo.sv
// two-entry request queue between front and back end
`default_nettype none
module spp_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  spp_pkg::work_t       push_data,
  output logic                 pop_valid,
  output spp_pkg::work_t       pop_data,
  output logic                 full
);

  spp_pkg::work_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];
  assign full      = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/spp_cordic.sv
// pipelined vectoring rotator, one stage per iteration
`default_nettype none
module spp_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  spp_pkg::cval_t       in_re,
  input  spp_pkg::cval_t       in_im,
  input  spp_pkg::ang_t        in_acc,
  input  spp_pkg::side_t       in_side,
  output logic                 out_valid,
  output spp_pkg::cval_t       out_re,
  output spp_pkg::ang_t        out_acc,
  output spp_pkg::side_t       out_side
);

  localparam int N = spp_pkg::CORDIC_STAGES;

  logic           v_r   [N];
  spp_pkg::cval_t re_r  [N];
  spp_pkg::cval_t im_r  [N];
  spp_pkg::ang_t  acc_r [N];
  spp_pkg::side_t sd_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic           pv;
    spp_pkg::cval_t pre, pim;
    spp_pkg::ang_t  pacc;
    spp_pkg::side_t psd;
    if (i == 0) begin : g_first
      assign pv   = in_valid;
      assign pre  = in_re;
      assign pim  = in_im;
      assign pacc = in_acc;
      assign psd  = in_side;
    end else begin : g_next
      assign pv   = v_r[i-1];
      assign pre  = re_r[i-1];
      assign pim  = im_r[i-1];
      assign pacc = acc_r[i-1];
      assign psd  = sd_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= pv;
      end
      sd_r[i] <= psd;
      if (pim[spp_pkg::CW-1]) begin
        re_r[i]  <= pre - (pim >>> i);
        im_r[i]  <= pim + (pre >>> i);
        acc_r[i] <= pacc - spp_pkg::ang_t'(spp_pkg::ATAN_TAB[i]);
      end else begin
        re_r[i]  <= pre + (pim >>> i);
        im_r[i]  <= pim - (pre >>> i);
        acc_r[i] <= pacc + spp_pkg::ang_t'(spp_pkg::ATAN_TAB[i]);
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_re    = re_r[N-1];
  assign out_acc   = acc_r[N-1];
  assign out_side  = sd_r[N-1];

endmodule
`default_nettype wire

### hdl/spp_gain.sv
// gain compensation of a vectoring magnitude: registered partial products, then a registered sum
`default_nettype none
module spp_gain (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  spp_pkg::cval_t       in_val,
  input  spp_pkg::ang_t        in_acc,
  input  spp_pkg::side_t       in_side,
  output logic                 out_valid,
  output spp_pkg::cval_t       out_val,
  output spp_pkg::ang_t        out_acc,
  output spp_pkg::side_t       out_side
);

  logic [55:0]    hi_r;
  logic [63:0]    lo_r;
  logic           v_r;
  spp_pkg::ang_t  acc_r;
  spp_pkg::side_t sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_r       <= in_valid;
      out_valid <= v_r;
    end
    hi_r     <= in_val[spp_pkg::CW-1:32] * spp_pkg::GAIN_INV;
    lo_r     <= in_val[31:0] * spp_pkg::GAIN_INV;
    acc_r    <= in_acc;
    sd_r     <= in_side;
    out_val  <= spp_pkg::cval_t'(hi_r + 56'(lo_r[63:32]));
    out_acc  <= acc_r;
    out_side <= sd_r;
  end

endmodule
`default_nettype wire

### hdl/spp_back.sv
// back end: longitude and latitude rotators, radius and pixel mapping
`default_nettype none
module spp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  spp_pkg::work_t       in_work,
  input  wire logic [31:0]     image_size,
  input  wire logic [31:0]     max_dist,
  output logic                 out_valid,
  output logic [17:0]          out_pixel_u,
  output logic [17:0]          out_pixel_v,
  output logic [31:0]          out_range_out,
  output logic                 out_in_range
);

  logic           ca_v, ga_v, cb_v, gb_v;
  spp_pkg::cval_t ca_re, ga_val, cb_re, gb_val;
  spp_pkg::ang_t  ca_acc, ga_acc, cb_acc, gb_acc;
  spp_pkg::side_t ca_sd, ga_sd, cb_sd, gb_sd;

  logic           b_v_r;
  spp_pkg::cval_t b_re_r, b_im_r;
  spp_pkg::side_t b_sd_r;
  spp_pkg::cval_t rxy;
  spp_pkg::ang_t  theta;

  spp_cordic u_cordic_lon (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid),
    .in_re(in_work.re), .in_im(in_work.im), .in_acc(in_work.acc),
    .in_side(in_work.side),
    .out_valid(ca_v), .out_re(ca_re), .out_acc(ca_acc), .out_side(ca_sd)
  );

  spp_gain u_gain_lon (
    .clk(clk), .rst_n(rst_n), .in_valid(ca_v), .in_val(ca_re),
    .in_acc(ca_acc), .in_side(ca_sd),
    .out_valid(ga_v), .out_val(ga_val), .out_acc(ga_acc), .out_side(ga_sd)
  );

  always_comb begin
    rxy   = ga_sd.zero ? '0 : ga_val;
    theta = ga_sd.zero ? '0 : ga_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= ga_v;
    end
    b_re_r       <= rxy;
    b_im_r       <= ga_sd.z;
    b_sd_r.zero  <= (rxy == '0) && (ga_sd.z == '0);
    b_sd_r.theta <= theta;
    b_sd_r.z     <= '0;
  end

  spp_cordic u_cordic_lat (
    .clk(clk), .rst_n(rst_n), .in_valid(b_v_r),
    .in_re(b_re_r), .in_im(b_im_r), .in_acc('0), .in_side(b_sd_r),
    .out_valid(cb_v), .out_re(cb_re), .out_acc(cb_acc), .out_side(cb_sd)
  );

  spp_gain u_gain_lat (
    .clk(clk), .rst_n(rst_n), .in_valid(cb_v), .in_val(cb_re),
    .in_acc(cb_acc), .in_side(cb_sd),
    .out_valid(gb_v), .out_val(gb_val), .out_acc(gb_acc), .out_side(gb_sd)
  );

  // clamp and range
  spp_pkg::ang_t  phi;
  logic [56:0]    rr;
  logic [40:0]    radius;
  logic signed [34:0] t_full, s_full;
  logic [32:0]    t_nxt;
  logic [31:0]    s_nxt;

  logic           m1_v_r, m2_v_r;
  logic [32:0]    t_r;
  logic [31:0]    s_r;
  logic [31:0]    rng1_r, rng2_r;
  logic           inr1_r, inr2_r;
  logic [48:0]    pu_r;
  logic [47:0]    pv_r;

  always_comb begin
    phi    = gb_sd.zero ? '0 : gb_acc;
    rr     = gb_sd.zero ? '0 : ({1'b0, gb_val} + 57'd32768);
    radius = rr[56:16];
    t_full = 35'(spp_pkg::HALF_TURN) + 35'(gb_sd.theta);
    s_full = 35'sd1073741824 - 35'(phi);
    priority if (t_full < 0) begin
      t_nxt = '0;
    end else if (t_full > 35'sd4294967296) begin
      t_nxt = 33'h100000000;
    end else begin
      t_nxt = t_full[32:0];
    end
    priority if (s_full < 0) begin
      s_nxt = '0;
    end else if (s_full > 35'sd2147483648) begin
      s_nxt = 32'h80000000;
    end else begin
      s_nxt = s_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r    <= 1'b0;
      m2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      m1_v_r    <= gb_v;
      m2_v_r    <= m1_v_r;
      out_valid <= m2_v_r;
    end
    t_r    <= t_nxt;
    s_r    <= s_nxt;
    rng1_r <= (|radius[40:32]) ? 32'hFFFFFFFF : radius[31:0];
    inr1_r <= (radius <= {9'd0, max_dist});
    pu_r   <= image_size[15:0] * t_r;
    pv_r   <= image_size[31:16] * s_r;
    rng2_r <= rng1_r;
    inr2_r <= inr1_r;
  end

  // rounding and saturation
  logic [49:0] ua;
  logic [48:0] va;

  always_comb begin
    ua = 50'(pu_r) + 50'd134217728;
    va = 49'(pv_r) + 49'd67108864;
  end

  always_ff @(posedge clk) begin
    out_pixel_u   <= (|ua[49:46]) ? 18'h3FFFF : ua[45:28];
    out_pixel_v   <= (|va[48:45]) ? 18'h3FFFF : va[44:27];
    out_range_out <= rng2_r;
    out_in_range  <= inr2_r;
  end

endmodule
`default_nettype wire

### hdl/spherical_point_projection.sv
// top level of the spherical point projection block
// throughput: one request per cycle while busy is low, set by the fully pipelined rotators
// reset: synchronous active-low rst_n clears control state and loads the identity pose
// results appear for one cycle on out_valid and cannot be stalled
`default_nettype none
module spherical_point_projection (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [31:0]              in_point_x,
  input  wire logic signed [31:0]              in_point_y,
  input  wire logic signed [31:0]              in_point_z,
  output logic                                 out_valid,
  output logic [17:0]                          out_pixel_u,
  output logic [17:0]                          out_pixel_v,
  output logic [31:0]                          out_range_out,
  output logic                                 out_in_range,
  input  wire logic                            cfg_we,
  input  wire logic [spp_pkg::IDXW-1:0]        cfg_index,
  input  wire logic [spp_pkg::CFGW-1:0]        cfg_data
);

  logic [spp_pkg::CFGW-1:0] rot_row0_r, rot_row1_r, rot_row2_r;
  logic signed [31:0]       shift_x_r, shift_y_r, shift_z_r;
  logic [31:0]              image_size_r, max_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row0_r   <= spp_pkg::ROT_ROW0_RST;
      rot_row1_r   <= spp_pkg::ROT_ROW1_RST;
      rot_row2_r   <= spp_pkg::ROT_ROW2_RST;
      shift_x_r    <= '0;
      shift_y_r    <= '0;
      shift_z_r    <= '0;
      image_size_r <= '0;
      max_dist_r   <= spp_pkg::MAX_DIST_RST;
    end else if (cfg_we) begin
      unique case (spp_pkg::reg_idx_t'(cfg_index))
        spp_pkg::REG_ROT_ROW0:   rot_row0_r   <= cfg_data;
        spp_pkg::REG_ROT_ROW1:   rot_row1_r   <= cfg_data;
        spp_pkg::REG_ROT_ROW2:   rot_row2_r   <= cfg_data;
        spp_pkg::REG_SHIFT_X:    shift_x_r    <= cfg_data[31:0];
        spp_pkg::REG_SHIFT_Y:    shift_y_r    <= cfg_data[31:0];
        spp_pkg::REG_SHIFT_Z:    shift_z_r    <= cfg_data[31:0];
        spp_pkg::REG_IMAGE_SIZE: image_size_r <= cfg_data[31:0];
        spp_pkg::REG_MAX_DIST:   max_dist_r   <= cfg_data[31:0];
      endcase
    end
  end

  logic           take;
  logic           fr_v, q_v, q_full;
  spp_pkg::work_t fr_work, q_work;

  assign take = start && !busy;
  assign busy = q_full;

  spp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_take(take),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .rot_row0(rot_row0_r), .rot_row1(rot_row1_r), .rot_row2(rot_row2_r),
    .shift_x(shift_x_r), .shift_y(shift_y_r), .shift_z(shift_z_r),
    .out_valid(fr_v), .out_work(fr_work)
  );

  spp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(fr_v), .push_data(fr_work),
    .pop_valid(q_v), .pop_data(q_work), .full(q_full)
  );

  spp_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_v), .in_work(q_work),
    .image_size(image_size_r), .max_dist(max_dist_r),
    .out_valid(out_valid), .out_pixel_u(out_pixel_u), .out_pixel_v(out_pixel_v),
    .out_range_out(out_range_out), .out_in_range(out_in_range)
  );

endmodule
`default_nettype wire
